@@ sv/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Field widths, operation and status codes, payload and cell control types.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int KIND_W   = 2;
    localparam int TAG_IN_W = 16;
    localparam int PRIO_W   = 32;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PEEK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NOP    = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic [TAG_IN_W-1:0]        item_tag;
        logic signed [PRIO_W-1:0]   priority_req;
    } t_req;

    typedef struct packed {
        logic [TAG_IN_W-1:0]        out_tag;
        logic signed [PRIO_W-1:0]   out_priority;
        logic [STATUS_W-1:0]        status;
        logic [FILL_W-1:0]          fill_level;
    } t_rsp;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_cmd;

endpackage

@@ sv/spq_stream_if.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue stream channel
// Valid/ready channel carrying one item of the given payload type.
// ----------------------------------------------------------------------------
interface spq_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/spq_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One queue slot: holds a priority and tag, shifts toward the back on an
// insert in front of it and toward the front on a remove.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
#(
    parameter int TAG_W = 16
) (
    input  logic                     i_clk,
    input  t_cell_cmd                i_cmd,
    input  logic                     i_valid,
    input  logic signed [PRIO_W-1:0] i_new_prio,
    input  logic [TAG_W-1:0]         i_new_tag,
    input  logic                     i_prev_ge,
    input  logic signed [PRIO_W-1:0] i_prev_prio,
    input  logic [TAG_W-1:0]         i_prev_tag,
    input  logic signed [PRIO_W-1:0] i_next_prio,
    input  logic [TAG_W-1:0]         i_next_tag,
    output logic                     o_ge,
    output logic signed [PRIO_W-1:0] o_prio,
    output logic [TAG_W-1:0]         o_tag
);

    logic signed [PRIO_W-1:0] r_prio;
    logic [TAG_W-1:0]         r_tag;
    logic signed [PRIO_W-1:0] n_prio;
    logic [TAG_W-1:0]         n_tag;

    // new entry belongs at or in front of this slot; empty slots always qualify
    assign o_ge = !i_valid || (i_new_prio <= r_prio);

    always_comb begin
        n_prio = r_prio;
        n_tag  = r_tag;
        if (i_cmd.ins) begin
            if (o_ge && i_prev_ge) begin
                n_prio = i_prev_prio;
                n_tag  = i_prev_tag;
            end else if (o_ge) begin
                n_prio = i_new_prio;
                n_tag  = i_new_tag;
            end
        end else if (i_cmd.rem) begin
            n_prio = i_next_prio;
            n_tag  = i_next_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_tag  <= n_tag;
    end

    assign o_prio = r_prio;
    assign o_tag  = r_tag;

endmodule

@@ sv/sorted_priority_queue_top.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue, top level
// Min-priority queue held in a chain of DEPTH cells kept in ascending order.
// The result is registered in the cycle after acceptance. Throughput: one
// operation per cycle while results are taken; every cell updates in the same
// cycle from its neighbors, so no search or shift loop stalls the request
// side. Reset: synchronous active low; clears the entry count and the result
// valid. Cell contents are not reset, only slots below the count are read.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int TAG_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    spq_stream_if.sink           i_req,
    spq_stream_if.source         o_rsp
);

    // stored tag width: only the low TAG_WIDTH bits of the tag field are kept
    localparam int TW = (TAG_WIDTH < TAG_IN_W) ? TAG_WIDTH : TAG_IN_W;
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    t_rsp          r_rsp;
    t_rsp          n_rsp;
    t_req          req;
    logic          fire;
    logic          full;
    logic          empty;
    t_cell_cmd     cmd;

    // cell chain wiring
    logic                     cell_ge   [DEPTH];
    logic signed [PRIO_W-1:0] cell_prio [DEPTH];
    logic [TW-1:0]            cell_tag  [DEPTH];
    logic [TW-1:0]            new_tag;

    assign req     = i_req.payload;
    assign new_tag = req.item_tag[TW-1:0];

    // output register frees the request side as soon as the result is taken;
    // no item is taken while reset is held
    assign i_req.ready = i_rst_n && (!r_out_valid || o_rsp.ready);
    assign fire        = i_req.valid && i_req.ready;

    assign full  = (r_count == CW'(DEPTH));
    assign empty = (r_count == '0);

    assign cmd.ins = fire && (req.kind == KIND_INSERT) && !full;
    assign cmd.rem = fire && (req.kind == KIND_REMOVE) && !empty;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic                     prev_ge;
            logic signed [PRIO_W-1:0] prev_prio;
            logic [TW-1:0]            prev_tag;
            logic signed [PRIO_W-1:0] next_prio;
            logic [TW-1:0]            next_tag;
            logic                     slot_valid;

            assign slot_valid = (CW'(gi) < r_count);

            if (gi == 0) begin : g_head
                // front slot has nothing ahead of it to shift in
                assign prev_ge   = 1'b0;
                assign prev_prio = '0;
                assign prev_tag  = '0;
            end else begin : g_body
                assign prev_ge   = cell_ge[gi-1];
                assign prev_prio = cell_prio[gi-1];
                assign prev_tag  = cell_tag[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                // back slot drains to don't-care on remove; it is past the count
                assign next_prio = '0;
                assign next_tag  = '0;
            end else begin : g_inner
                assign next_prio = cell_prio[gi+1];
                assign next_tag  = cell_tag[gi+1];
            end

            spq_cell #(
                .TAG_W (TW)
            ) u_cell (
                .i_clk       (i_clk),
                .i_cmd       (cmd),
                .i_valid     (slot_valid),
                .i_new_prio  (req.priority_req),
                .i_new_tag   (new_tag),
                .i_prev_ge   (prev_ge),
                .i_prev_prio (prev_prio),
                .i_prev_tag  (prev_tag),
                .i_next_prio (next_prio),
                .i_next_tag  (next_tag),
                .o_ge        (cell_ge[gi]),
                .o_prio      (cell_prio[gi]),
                .o_tag       (cell_tag[gi])
            );
        end
    endgenerate

    // result and new count for the accepted item
    always_comb begin
        n_count            = r_count;
        n_rsp.out_tag      = '0;
        n_rsp.out_priority = '0;
        n_rsp.status       = STATUS_OK;
        unique case (req.kind)
            KIND_INSERT: begin
                if (full) begin
                    n_rsp.status = STATUS_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            KIND_PEEK, KIND_REMOVE: begin
                if (empty) begin
                    n_rsp.status = STATUS_EMPTY;
                end else begin
                    n_rsp.out_tag      = TAG_IN_W'(cell_tag[0]);
                    n_rsp.out_priority = cell_prio[0];
                    if (req.kind == KIND_REMOVE) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            KIND_NOP: begin
                n_count = r_count;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_rsp.fill_level = FILL_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_rsp;

endmodule

@@ tb/sv/sorted_priority_queue_top_tb.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives insert, peek, remove and no-op requests into the queue and checks
// every response against its table value or a behavioral copy of the queue
// kept in the bench. A short table of hand-checked steps covers empty, full,
// equal priorities and the extreme priorities; random fill/drain phases
// follow. Both channel sides idle at random, and the response side is held
// off once for a long stretch so the request side backs up.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top_tb;
    import spq_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 11;
    localparam int QDEPTH          = 16;
    localparam int QTAG_W          = 16;
    localparam int RANDOM_ITEMS    = 1800;
    localparam int HOLD_CYCLES     = 250;
    localparam int HOLD_AFTER      = 525;
    localparam int DRAIN_LIMIT     = 2000;
    localparam int TAIL_CYCLES     = 4;
    localparam int WATCHDOG_CYCLES = 600000;

    localparam logic [TAG_IN_W-1:0]      TAG_KEEP     = TAG_IN_W'((64'd1 << QTAG_W) - 1);
    localparam logic signed [PRIO_W-1:0] PRIO_MIN     = 32'sh8000_0000;
    localparam logic signed [PRIO_W-1:0] PRIO_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [PRIO_W-1:0] PRIO_NEG_ONE = -32'sd1;

    // traffic mix of one random phase
    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED
    } t_phase;

    // one offered request, with a hand-written response where one is known
    typedef struct {
        t_req req;
        bit   known;
        t_rsp want;
    } t_step;

    logic i_clk;
    logic i_rst_n;

    spq_stream_if #(.t_payload(t_req)) req_if ();
    spq_stream_if #(.t_payload(t_rsp)) rsp_if ();

    sorted_priority_queue_top #(
        .DEPTH     (QDEPTH),
        .TAG_WIDTH (QTAG_W)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // bench copy of the queue contents, front entry at index 0
    logic signed [PRIO_W-1:0] q_prio [QDEPTH];
    logic [TAG_IN_W-1:0]      q_tag  [QDEPTH];
    int                       q_count;

    t_rsp  expected_rsp [$];   // responses still owed by the queue, oldest first
    t_step sent_steps   [$];   // requests offered, in order, awaiting acceptance
    int    n_errors;
    int    n_accepted;
    bit    idle_on;            // random gaps on both channel sides
    bit    rsp_hold;           // long response-side hold-off in progress

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    always begin
        i_clk = 1'b0;
        #(CLK_PERIOD / 2);
        i_clk = 1'b1;
        #(CLK_PERIOD / 2);
    end

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        n_errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // Apply one request to the bench queue and return the response it owes.
    // Insert goes in front of the first entry with priority >= its own, so the
    // newest of equal priorities comes out first. Failed ops leave state alone.
    function automatic t_rsp queue_apply(input t_req r);
        t_rsp res;
        int   pos;
        int   i;
        res = '0;
        case (r.kind)
            KIND_INSERT: begin
                if (q_count >= QDEPTH) begin
                    res.status = STATUS_FULL;
                end else begin
                    pos = q_count;
                    for (i = q_count - 1; i >= 0; i--)
                        if ($signed(r.priority_req) <= q_prio[i])
                            pos = i;
                    for (i = q_count; i > pos; i--) begin
                        q_prio[i] = q_prio[i-1];
                        q_tag[i]  = q_tag[i-1];
                    end
                    q_prio[pos] = r.priority_req;
                    q_tag[pos]  = r.item_tag & TAG_KEEP;
                    q_count++;
                end
            end
            KIND_PEEK, KIND_REMOVE: begin
                if (q_count == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    res.out_tag      = q_tag[0];
                    res.out_priority = q_prio[0];
                    if (r.kind == KIND_REMOVE) begin
                        for (i = 0; i + 1 < q_count; i++) begin
                            q_prio[i] = q_prio[i+1];
                            q_tag[i]  = q_tag[i+1];
                        end
                        q_count--;
                    end
                end
            end
            default: ;  // no-op: nothing changes, status ok
        endcase
        res.fill_level = FILL_W'(q_count);
        return res;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!idle_on || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind(input t_phase phase);
        int unsigned roll;
        int unsigned ins_cut;
        int unsigned peek_cut;
        roll = $urandom_range(0, 99);
        case (phase)
            PH_FILL:  begin ins_cut = 80; peek_cut = 90; end
            PH_DRAIN: begin ins_cut = 15; peek_cut = 35; end
            default:  begin ins_cut = 45; peek_cut = 65; end
        endcase
        if (roll < 4)
            return KIND_NOP;
        if (roll < ins_cut)
            return KIND_INSERT;
        if (roll < peek_cut)
            return KIND_PEEK;
        return KIND_REMOVE;
    endfunction

    // Narrow band around zero gives plenty of ties; extremes show up often.
    function automatic logic signed [PRIO_W-1:0] pick_priority();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        case (roll)
            0:       return PRIO_MIN;
            1:       return PRIO_MAX;
            2:       return PRIO_NEG_ONE;
            3, 4, 5: return $signed(PRIO_W'($urandom_range(0, 8))) - 32'sd4;
            default: return $signed(PRIO_W'($urandom()));
        endcase
    endfunction

    function automatic t_step mk_step(
        input logic [KIND_W-1:0]          kind,
        input logic [TAG_IN_W-1:0]        tag,
        input logic signed [PRIO_W-1:0]   prio,
        input logic [TAG_IN_W-1:0]        o_tag,
        input logic signed [PRIO_W-1:0]   o_prio,
        input logic [STATUS_W-1:0]        st,
        input logic [FILL_W-1:0]          fill
    );
        t_step s;
        s.req.kind          = kind;
        s.req.item_tag      = tag;
        s.req.priority_req  = prio;
        s.known             = 1'b1;
        s.want.out_tag      = o_tag;
        s.want.out_priority = o_prio;
        s.want.status       = st;
        s.want.fill_level   = fill;
        return s;
    endfunction

    // Offer one request and return at the edge where it is taken. Valid stays
    // high across back-to-back items; it only drops when a gap is drawn.
    task automatic offer(input t_req r, input bit known, input t_rsp want);
        int unsigned gap;
        t_step       s;
        gap = pick_gap();
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s.req   = r;
        s.known = known;
        s.want  = want;
        sent_steps.push_back(s);
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // ------------------------------------------------------------------------
    // Monitor: responses are checked before the request taken at the same
    // edge is predicted, since a response always belongs to an older request.
    // Table steps with a hand-written response are held to that; the bench
    // queue still advances on them so later predictions stay in step.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rsp  got;
        t_rsp  want;
        t_rsp  pred;
        t_step s;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                got = rsp_if.payload;
                if (expected_rsp.size() == 0) begin
                    report_mismatch("response with nothing outstanding");
                end else begin
                    want = expected_rsp.pop_front();
                    check_field("out_tag", 32'(got.out_tag), 32'(want.out_tag));
                    check_field("out_priority", got.out_priority, want.out_priority);
                    check_field("status", 32'(got.status), 32'(want.status));
                    check_field("fill_level", 32'(got.fill_level), 32'(want.fill_level));
                end
            end
            if (req_if.valid && req_if.ready) begin
                pred = queue_apply(req_if.payload);
                if (sent_steps.size() != 0) begin
                    s = sent_steps.pop_front();
                    expected_rsp.push_back(s.known ? s.want : pred);
                end else begin
                    expected_rsp.push_back(pred);
                end
                n_accepted++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response side: random ready with gaps; forced low during the hold-off.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned gap;
        rsp_if.ready = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            gap = rsp_hold ? 1 : pick_gap();
            if (gap != 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                rsp_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Long hold-off on the response side partway into the random phase; the
    // request side keeps offering, so the queue output backs up and stalls.
    initial begin
        rsp_hold = 1'b0;
        wait (n_accepted >= HOLD_AFTER);
        @(posedge i_clk);
        rsp_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rsp_hold = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        t_step  plan [$];
        t_req   r;
        t_phase phase;
        int     k;
        int     len;
        int     n_counted;
        int     waited;

        n_errors       = 0;
        n_accepted     = 0;
        q_count        = 0;
        idle_on        = 1'b1;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        i_rst_n        = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. Empty queue first: peek/remove report empty,
        // no-op reports ok with nothing queued.
        plan.push_back(mk_step(KIND_PEEK,   16'h0000, 32'sd0, 16'h0, 32'sd0, STATUS_EMPTY, 5'd0));
        plan.push_back(mk_step(KIND_REMOVE, 16'h0000, 32'sd0, 16'h0, 32'sd0, STATUS_EMPTY, 5'd0));
        plan.push_back(mk_step(KIND_NOP,    16'h0000, 32'sd0, 16'h0, 32'sd0, STATUS_OK,    5'd0));
        // extremes, then two equal priorities; the later one must lead
        plan.push_back(mk_step(KIND_INSERT, 16'hFFFF, PRIO_MAX, 16'h0, 32'sd0, STATUS_OK, 5'd1));
        plan.push_back(mk_step(KIND_INSERT, 16'h0000, PRIO_MIN, 16'h0, 32'sd0, STATUS_OK, 5'd2));
        plan.push_back(mk_step(KIND_INSERT, 16'h0001, PRIO_NEG_ONE, 16'h0, 32'sd0, STATUS_OK, 5'd3));
        plan.push_back(mk_step(KIND_INSERT, 16'h0002, PRIO_NEG_ONE, 16'h0, 32'sd0, STATUS_OK, 5'd4));
        // fill to the brim with scattered positive priorities
        for (k = 0; k < 12; k++)
            plan.push_back(mk_step(KIND_INSERT, TAG_IN_W'(16'h0010 + k),
                                   32'sd100 + PRIO_W'((k * 613) % 1000),
                                   16'h0, 32'sd0, STATUS_OK, FILL_W'(5 + k)));
        // insert into a full queue is refused, count unchanged
        plan.push_back(mk_step(KIND_INSERT, 16'hABCD, 32'sd5, 16'h0, 32'sd0, STATUS_FULL, 5'd16));
        plan.push_back(mk_step(KIND_PEEK,   16'h0000, 32'sd0, 16'h0000, PRIO_MIN, STATUS_OK, 5'd16));
        plan.push_back(mk_step(KIND_REMOVE, 16'h0000, 32'sd0, 16'h0000, PRIO_MIN, STATUS_OK, 5'd15));
        plan.push_back(mk_step(KIND_REMOVE, 16'h0000, 32'sd0, 16'h0002, PRIO_NEG_ONE,
                               STATUS_OK, 5'd14));
        plan.push_back(mk_step(KIND_REMOVE, 16'h0000, 32'sd0, 16'h0001, PRIO_NEG_ONE,
                               STATUS_OK, 5'd13));
        // no-op with busy fields still reports zeros
        plan.push_back(mk_step(KIND_NOP, 16'hFFFF, PRIO_NEG_ONE, 16'h0, 32'sd0, STATUS_OK, 5'd13));

        foreach (plan[i])
            offer(plan[i].req, plan[i].known, plan[i].want);

        // Random phases: fill bursts run into full, drain bursts into empty,
        // mixed ones wander in between. Some phases run with no idling.
        n_counted = 0;
        while (n_counted < RANDOM_ITEMS) begin
            phase   = t_phase'($urandom_range(0, 2));
            len     = $urandom_range(8, 60);
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (len) begin
                r.kind         = pick_kind(phase);
                r.item_tag     = TAG_IN_W'($urandom());
                r.priority_req = pick_priority();
                offer(r, 1'b0, '0);
                if (r.kind != KIND_NOP)
                    n_counted++;
            end
        end

        // Drain: stop offering, keep the response side open, let the
        // output register settle.
        req_if.valid <= 1'b0;
        idle_on = 1'b0;
        @(posedge i_clk);
        waited = 0;
        while (expected_rsp.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_rsp.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", expected_rsp.size()));

        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #(CLK_PERIOD * WATCHDOG_CYCLES);
        $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/spq_pkg.sv
sv/spq_stream_if.sv
sv/spq_cell.sv
sv/sorted_priority_queue_top.sv
tb/sv/sorted_priority_queue_top_tb.sv
